@@ hdl/oale_pkg.sv @@
// ----------------------------------------------------------------------------
// oale_pkg
// Shared types and constants of the ordered array list engine.
// ----------------------------------------------------------------------------
package oale_pkg;

  localparam int Capacity   = 16;
  localparam int ValueWidth = 32;
  localparam int IdxW       = $clog2(Capacity);
  localparam int CntW       = $clog2(Capacity + 1);

  typedef enum logic [2:0] {
    OP_INSERT_AT     = 3'd0,
    OP_INSERT_SORTED = 3'd1,
    OP_ERASE_AT      = 3'd2,
    OP_REMOVE_ALL    = 3'd3,
    OP_GET           = 3'd4,
    OP_SET           = 3'd5,
    OP_FIND          = 3'd6
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_POS_RANGE = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CM_HOLD,
    CM_INSERT,
    CM_ERASE,
    CM_WRITE
  } cell_mode_e;

  typedef struct packed {
    logic [2:0]            opcode;
    logic [4:0]            position;
    logic [ValueWidth-1:0] value_in;
  } cmd_t;

  typedef struct packed {
    status_e               status;
    logic [IdxW-1:0]       index_out;
    logic [ValueWidth-1:0] value_out;
    logic [CntW-1:0]       removed_count;
    logic [CntW-1:0]       size_now;
    logic                  is_empty;
  } result_t;

  typedef struct packed {
    cell_mode_e            mode;
    logic [CntW-1:0]       target;
    logic [CntW-1:0]       count;
    logic [ValueWidth-1:0] key;
  } cell_ctl_t;

  typedef struct packed {
    logic                  hit;
    logic                  stop;
  } cell_stat_t;

endpackage

@@ hdl/ordered_array_list_engine_top.sv @@
// ----------------------------------------------------------------------------
// ordered_array_list_engine_top
// Fixed-capacity ordered list held in a row of shifting slots.
// ----------------------------------------------------------------------------
// Every operation except remove_all returns its result beat on done_o in the
// cycle after the command is taken, and a new command may be given in that
// same cycle. Remove_all erases one matching entry per cycle through the slot
// row, keeps busy high while matches remain and then returns its result
// beat. The result is shown for one cycle only and must be captured then.
module ordered_array_list_engine_top
  import oale_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  input  cmd_t    cmd_i,
  output logic    busy,
  output logic    done_o,
  output result_t result_o
);

  typedef enum logic {
    S_IDLE,
    S_REMOVE
  } state_e;

  state_e                state_q, state_d;
  logic [CntW-1:0]       count_q, count_d;
  logic [CntW-1:0]       removed_q, removed_d;
  logic [ValueWidth-1:0] key_q;
  logic                  done_q, done_d;
  result_t               res_q, res_d;

  cell_ctl_t             ctl;
  logic [ValueWidth-1:0] vals [Capacity];
  cell_stat_t            stats [Capacity];

  logic                  hit_any, stop_any;
  logic [IdxW-1:0]       hit_idx, stop_idx;
  logic [CntW-1:0]       sort_tgt;
  logic [4:0]            pos;

  assign busy     = (state_q == S_REMOVE);
  assign done_o   = done_q;
  assign result_o = res_q;
  assign pos      = cmd_i.position;

  for (genvar g = 0; g < Capacity; g++) begin : g_cell
    logic [ValueWidth-1:0] left, right;
    if (g == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid
      assign left = vals[g-1];
    end
    if (g == Capacity - 1) begin : g_last
      assign right = '0;
    end else begin : g_inner
      assign right = vals[g+1];
    end
    oale_cell #(.CellIdx(g)) u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .left_i  (left),
      .right_i (right),
      .value_o (vals[g]),
      .stat_o  (stats[g])
    );
  end

  always_comb begin
    hit_any  = 1'b0;
    stop_any = 1'b0;
    hit_idx  = '0;
    stop_idx = '0;
    for (int i = Capacity - 1; i >= 0; i--) begin
      if (stats[i].hit) begin
        hit_any = 1'b1;
        hit_idx = IdxW'(i);
      end
      if (stats[i].stop) begin
        stop_any = 1'b1;
        stop_idx = IdxW'(i);
      end
    end
    sort_tgt = stop_any ? CntW'(stop_idx) : count_q;
  end

  always_comb begin
    ctl.mode   = CM_HOLD;
    ctl.target = pos;
    ctl.count  = count_q;
    ctl.key    = busy ? key_q : cmd_i.value_in;
    state_d    = state_q;
    count_d    = count_q;
    removed_d  = removed_q;
    done_d     = 1'b0;
    res_d      = res_q;
    res_d.status        = ST_OK;
    res_d.index_out     = '0;
    res_d.value_out     = '0;
    res_d.removed_count = '0;
    if (state_q == S_REMOVE) begin
      if (hit_any) begin
        ctl.mode   = CM_ERASE;
        ctl.target = CntW'(hit_idx);
        count_d    = count_q - CntW'(1);
        removed_d  = removed_q + CntW'(1);
      end else begin
        done_d              = 1'b1;
        res_d.removed_count = removed_q;
        state_d             = S_IDLE;
      end
    end else if (start) begin
      done_d = 1'b1;
      unique case (cmd_i.opcode)
        OP_INSERT_AT: begin
          if (pos > count_q) begin
            res_d.status = ST_POS_RANGE;
          end else if (count_q >= CntW'(Capacity)) begin
            res_d.status = ST_FULL;
          end else begin
            ctl.mode        = CM_INSERT;
            count_d         = count_q + CntW'(1);
            res_d.index_out = pos[IdxW-1:0];
          end
        end
        OP_INSERT_SORTED: begin
          if (count_q >= CntW'(Capacity)) begin
            res_d.status = ST_FULL;
          end else begin
            ctl.mode        = CM_INSERT;
            ctl.target      = sort_tgt;
            count_d         = count_q + CntW'(1);
            res_d.index_out = sort_tgt[IdxW-1:0];
          end
        end
        OP_ERASE_AT: begin
          if (pos >= count_q) begin
            res_d.status = ST_POS_RANGE;
          end else begin
            ctl.mode = CM_ERASE;
            count_d  = count_q - CntW'(1);
          end
        end
        OP_REMOVE_ALL: begin
          removed_d = '0;
          if (hit_any) begin
            done_d     = 1'b0;
            ctl.mode   = CM_ERASE;
            ctl.target = CntW'(hit_idx);
            count_d    = count_q - CntW'(1);
            removed_d  = CntW'(1);
            state_d    = S_REMOVE;
          end
        end
        OP_GET: begin
          if (pos >= count_q) begin
            res_d.status = ST_POS_RANGE;
          end else begin
            res_d.value_out = vals[pos[IdxW-1:0]];
          end
        end
        OP_SET: begin
          if (pos >= count_q) begin
            res_d.status = ST_POS_RANGE;
          end else begin
            ctl.mode = CM_WRITE;
          end
        end
        OP_FIND: begin
          if (hit_any) begin
            res_d.index_out = hit_idx;
          end else begin
            res_d.status = ST_NOT_FOUND;
          end
        end
        default: ;
      endcase
    end
    res_d.size_now = count_d;
    res_d.is_empty = (count_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      removed_q <= '0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      removed_q <= removed_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (start && !busy) begin
      key_q <= cmd_i.value_in;
    end
  end

endmodule

@@ hdl/oale_cell.sv @@
// ----------------------------------------------------------------------------
// oale_cell
// One list slot: holds an entry, shifts with its neighbors, compares to key.
// ----------------------------------------------------------------------------
module oale_cell
  import oale_pkg::*;
#(
  parameter int CellIdx = 0
) (
  input  logic                  clk_i,
  input  cell_ctl_t             ctl_i,
  input  logic [ValueWidth-1:0] left_i,
  input  logic [ValueWidth-1:0] right_i,
  output logic [ValueWidth-1:0] value_o,
  output cell_stat_t            stat_o
);

  localparam logic [CntW-1:0] MyIdx = CntW'(CellIdx);

  logic [ValueWidth-1:0] value_q, value_d;
  logic                  valid;

  assign valid       = MyIdx < ctl_i.count;
  assign value_o     = value_q;
  assign stat_o.hit  = valid && (value_q == ctl_i.key);
  assign stat_o.stop = valid && !(ctl_i.key > value_q);

  always_comb begin
    value_d = value_q;
    unique case (ctl_i.mode)
      CM_INSERT: begin
        if (MyIdx > ctl_i.target) begin
          value_d = left_i;
        end else if (MyIdx == ctl_i.target) begin
          value_d = ctl_i.key;
        end
      end
      CM_ERASE: begin
        if (MyIdx >= ctl_i.target) begin
          value_d = right_i;
        end
      end
      CM_WRITE: begin
        if (MyIdx == ctl_i.target) begin
          value_d = ctl_i.key;
        end
      end
      CM_HOLD: value_d = value_q;
      default: value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

@@ hdl/oale_checker.sv @@
// ----------------------------------------------------------------------------
// oale_checker
// Port-level checks of the ordered array list engine.
// ----------------------------------------------------------------------------
module oale_checker
  import oale_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  input  logic    busy,
  input  logic    done_o,
  input  result_t result_o
);

  a_take_then_beat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (done_o || busy))
    else $error("accepted command gave neither a beat nor busy");

  a_busy_end_beat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("remove pass ended without a result beat");

  a_empty_flag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (result_o.is_empty == (result_o.size_now == '0)))
    else $error("empty flag disagrees with size");

  a_size_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (result_o.size_now <= CntW'(Capacity)))
    else $error("size beyond capacity");

  a_err_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.status != ST_OK) |->
      (result_o.value_out == '0 && result_o.removed_count == '0))
    else $error("failed beat carries data");

endmodule

bind ordered_array_list_engine_top oale_checker u_oale_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .done_o   (done_o),
  .result_o (result_o)
);
